/* rtl/arp_receive_cache_engine_macros.svh */
// Assertion macros shared by the cache engine RTL.
`ifndef ARP_RECEIVE_CACHE_ENGINE_MACROS_SVH
`define ARP_RECEIVE_CACHE_ENGINE_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ARP_RCE_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("arp cache engine check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ARP_RCE_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("arp cache engine check failed");

`endif

/* rtl/arp_rce_pkg.sv */
package arp_rce_pkg;

   // Cache geometry.
   localparam int CACHE_ENTRIES = 16;
   localparam int IDX_W         = $clog2(CACHE_ENTRIES);

   // Field widths.
   localparam int IP_W    = 32;
   localparam int MAC_W   = 48;
   localparam int ENTRY_W = IP_W + MAC_W;
   localparam int CSR_W   = 48;

   // Protocol constants.
   localparam logic [15:0] HTYPE_ETHERNET = 16'h0001;
   localparam logic [7:0]  HLEN_ETHERNET  = 8'd6;
   localparam logic [15:0] PTYPE_IPV4     = 16'h0800;
   localparam logic [15:0] OPCODE_REQUEST = 16'h0001;
   localparam logic [15:0] OPCODE_REPLY   = 16'h0002;

   // Configuration register indexes.
   typedef enum logic {
      CSR_OWN_IP  = 1'b0,
      CSR_OWN_MAC = 1'b1
   } csr_index_type;

   // Result status codes.
   typedef enum logic [1:0] {
      STATUS_FOR_US     = 2'd0,
      STATUS_NOT_FOR_US = 2'd1,
      STATUS_BAD_HW     = 2'd2,
      STATUS_BAD_PROTO  = 2'd3
   } status_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_WRITE,
      ST_FINISH
   } state_type;

   // Control strobes decoded from the sequencer state.
   typedef struct packed {
      logic req_ready;
      logic scan;
      logic compare;
      logic write;
      logic finish;
   } ctl_type;

endpackage

/* rtl/arp_rce_ram.sv */
module arp_rce_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Single write port and a registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/arp_receive_cache_engine.sv */
// ARP receive engine with an IPv4-to-Ethernet address cache.
// The req_ channel carries one decoded ARP packet per transfer; the rsp_
// channel returns exactly one result per packet, in order. Both channels use
// valid/ready. The csr_ port writes own_ip (index 0) and own_mac (index 1)
// with csr_we, and should only be used while no packet is in flight.
// A well-formed packet walks the whole cache memory, one entry per cycle over
// the single read port, then passes through the drain state for the last
// compare and the write state for the write-back; the result is then loaded
// into the output register, and the next request can be taken in the cycle
// after the result is loaded. Packets with a bad hardware or protocol field
// skip the walk and go straight to the write-back.
// The result sits in an output register, so a stalled receiver holds only
// that register: the next packet is accepted and processed, and it waits in
// the final state until the output register is taken.
// Reset clears all entry valid bits, the insert pointer and both address
// registers at once; no clearing pass is needed.
`include "arp_receive_cache_engine_macros.svh"

module arp_receive_cache_engine
   import arp_rce_pkg::*;
(
   input  logic             clock,
   input  logic             reset,

   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [CSR_W-1:0] csr_wdata,

   input  logic             req_valid,
   output logic             req_ready,
   input  logic [15:0]      req_hw_type,
   input  logic [7:0]       req_hw_len,
   input  logic [15:0]      req_proto_type,
   input  logic [15:0]      req_arp_op,
   input  logic [MAC_W-1:0] req_sender_mac,
   input  logic [IP_W-1:0]  req_sender_ip,
   input  logic [IP_W-1:0]  req_target_ip,

   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [1:0]       rsp_status,
   output logic             rsp_entry_updated,
   output logic             rsp_entry_inserted,
   output logic             rsp_entry_evicted,
   output logic             rsp_reply_valid,
   output logic [IP_W-1:0]  rsp_reply_target_ip,
   output logic [MAC_W-1:0] rsp_reply_target_mac
);

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_ENTRIES - 1);

   // Sequencer and control.
   state_type state_ff, state_in;
   ctl_type   ctl;

   // Configuration registers.
   logic [IP_W-1:0]  own_ip_ff;
   logic [MAC_W-1:0] own_mac_ff;

   // Captured packet.
   logic             hw_ok_ff;
   logic             proto_ok_ff;
   logic             is_request_ff;
   logic [MAC_W-1:0] sender_mac_ff;
   logic [IP_W-1:0]  sender_ip_ff;
   logic [IP_W-1:0]  target_ip_ff;

   // Cache state held in flip-flops.
   logic [CACHE_ENTRIES-1:0] valid_ff;
   logic [IDX_W-1:0]         insert_ptr_ff;

   // Scan bookkeeping.
   logic [IDX_W-1:0] scan_addr_ff;
   logic [IDX_W-1:0] rd_idx_ff;
   logic             rd_pend_ff;
   logic             found_ff;
   logic [IDX_W-1:0] slot_ff;

   // Memory port signals.
   logic               ram_we;
   logic [IDX_W-1:0]   ram_waddr;
   logic [ENTRY_W-1:0] ram_wdata;
   logic [ENTRY_W-1:0] ram_rdata;
   logic [IP_W-1:0]    rd_ip;
   logic               hit;

   // Write-back decisions.
   logic       pkt_ok;
   logic       target_match;
   logic       do_insert;
   logic       load_out;
   status_type status_in;

   // Result registers.
   logic             rsp_valid_ff;
   logic [1:0]       res_status_ff;
   logic             res_updated_ff;
   logic             res_inserted_ff;
   logic             res_evicted_ff;
   logic             res_reply_ff;
   logic [IP_W-1:0]  res_ip_ff;
   logic [MAC_W-1:0] res_mac_ff;
   logic [1:0]       out_status_ff;
   logic             out_updated_ff;
   logic             out_inserted_ff;
   logic             out_evicted_ff;
   logic             out_reply_ff;
   logic [IP_W-1:0]  out_ip_ff;
   logic [MAC_W-1:0] out_mac_ff;

   // Entry memory: sender MAC above sender IP.
   arp_rce_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (CACHE_ENTRIES)
   ) u_entry_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (scan_addr_ff),
      .rdata (ram_rdata)
   );

   assign rd_ip = ram_rdata[IP_W-1:0];
   assign hit   = ctl.compare && rd_pend_ff && valid_ff[rd_idx_ff] && (rd_ip == sender_ip_ff);

   // Header checks on the incoming packet.
   logic req_hw_ok;
   logic req_proto_ok;
   assign req_hw_ok    = (req_hw_type == HTYPE_ETHERNET) && (req_hw_len == HLEN_ETHERNET);
   assign req_proto_ok = (req_proto_type == PTYPE_IPV4);

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_hw_ok && req_proto_ok) ? ST_SCAN : ST_WRITE;
            end
         end
         ST_SCAN: begin
            if (scan_addr_ff == LAST_IDX) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control decode.
   always_comb begin
      ctl = '0;
      unique case (state_ff)
         ST_IDLE: begin
            ctl.req_ready = 1'b1;
         end
         ST_SCAN: begin
            ctl.scan    = 1'b1;
            ctl.compare = 1'b1;
         end
         ST_DRAIN: begin
            ctl.compare = 1'b1;
         end
         ST_WRITE: begin
            ctl.write = 1'b1;
         end
         ST_FINISH: begin
            ctl.finish = 1'b1;
         end
         default: begin
            ctl = '0;
         end
      endcase
   end

   assign req_ready = ctl.req_ready;

   // Write-back decision for the captured packet.
   assign pkt_ok       = hw_ok_ff && proto_ok_ff;
   assign target_match = (target_ip_ff == own_ip_ff);
   assign do_insert    = pkt_ok && target_match && !found_ff;
   assign ram_we       = ctl.write && pkt_ok && (found_ff || target_match);
   assign ram_waddr    = found_ff ? slot_ff : insert_ptr_ff;
   assign ram_wdata    = {sender_mac_ff, sender_ip_ff};
   assign load_out     = ctl.finish && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      if (!hw_ok_ff) begin
         status_in = STATUS_BAD_HW;
      end else if (!proto_ok_ff) begin
         status_in = STATUS_BAD_PROTO;
      end else if (target_match) begin
         status_in = STATUS_FOR_US;
      end else begin
         status_in = STATUS_NOT_FOR_US;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         own_ip_ff     <= '0;
         own_mac_ff    <= '0;
         valid_ff      <= '0;
         insert_ptr_ff <= '0;
         scan_addr_ff  <= '0;
         rd_pend_ff    <= 1'b0;
         found_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rd_pend_ff <= ctl.scan;

         // Configuration writes.
         if (csr_we) begin
            unique case (csr_index_type'(csr_index))
               CSR_OWN_IP:  own_ip_ff  <= csr_wdata[IP_W-1:0];
               CSR_OWN_MAC: own_mac_ff <= csr_wdata[MAC_W-1:0];
               default:     own_ip_ff  <= own_ip_ff;
            endcase
         end

         // Scan address walks the memory once per well-formed packet.
         if (ctl.req_ready && req_valid) begin
            scan_addr_ff <= '0;
            found_ff     <= 1'b0;
         end else begin
            if (ctl.scan) begin
               scan_addr_ff <= (scan_addr_ff == LAST_IDX) ? '0 : scan_addr_ff + 1'b1;
            end
            if (hit) begin
               found_ff <= 1'b1;
            end
         end

         // New entry goes into the round-robin slot.
         if (ctl.write && do_insert) begin
            valid_ff[insert_ptr_ff] <= 1'b1;
            insert_ptr_ff <= (insert_ptr_ff == LAST_IDX) ? '0 : insert_ptr_ff + 1'b1;
         end

         // Output register handshake.
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (ctl.req_ready && req_valid) begin
         hw_ok_ff      <= req_hw_ok;
         proto_ok_ff   <= req_proto_ok;
         is_request_ff <= (req_arp_op == OPCODE_REQUEST);
         sender_mac_ff <= req_sender_mac;
         sender_ip_ff  <= req_sender_ip;
         target_ip_ff  <= req_target_ip;
      end

      rd_idx_ff <= scan_addr_ff;

      // Keep the lowest matching slot.
      if (hit && !found_ff) begin
         slot_ff <= rd_idx_ff;
      end

      // Result of the write-back.
      if (ctl.write) begin
         res_status_ff   <= status_in;
         res_updated_ff  <= pkt_ok && found_ff;
         res_inserted_ff <= do_insert;
         res_evicted_ff  <= do_insert && valid_ff[insert_ptr_ff];
         res_reply_ff    <= pkt_ok && target_match && is_request_ff;
         res_ip_ff       <= (pkt_ok && target_match && is_request_ff) ? sender_ip_ff : '0;
         res_mac_ff      <= (pkt_ok && target_match && is_request_ff) ? sender_mac_ff : '0;
      end

      if (load_out) begin
         out_status_ff   <= res_status_ff;
         out_updated_ff  <= res_updated_ff;
         out_inserted_ff <= res_inserted_ff;
         out_evicted_ff  <= res_evicted_ff;
         out_reply_ff    <= res_reply_ff;
         out_ip_ff       <= res_ip_ff;
         out_mac_ff      <= res_mac_ff;
      end
   end

   // The own MAC does not leave this block; here it only feeds own_mac_set, which
   // the reply check below uses to test whether a source address is set.
   logic own_mac_set;
   assign own_mac_set = |own_mac_ff;

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = out_status_ff;
   assign rsp_entry_updated    = out_updated_ff;
   assign rsp_entry_inserted   = out_inserted_ff;
   assign rsp_entry_evicted    = out_evicted_ff;
   assign rsp_reply_valid      = out_reply_ff;
   assign rsp_reply_target_ip  = out_ip_ff;
   assign rsp_reply_target_mac = out_mac_ff;

   // Consistency checks.
   `ARP_RCE_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)
   `ARP_RCE_ASSERT_NOW(a_update_xor_insert, rsp_valid, !(rsp_entry_updated && rsp_entry_inserted))
   `ARP_RCE_ASSERT_NOW(a_evict_needs_insert, rsp_valid && rsp_entry_evicted, rsp_entry_inserted)
   `ARP_RCE_ASSERT_NOW(a_reply_only_for_us, rsp_valid && rsp_reply_valid,
                       rsp_status == STATUS_FOR_US || (own_mac_set && rsp_status == STATUS_FOR_US))

endmodule
